FILE: design/ufq_pkg.sv
package ufq_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int CMD_W    = 2;
  localparam int NUM_W    = 10;
  localparam int AHEAD_W  = 64;
  localparam int ATAIL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_SERVE   = 2'd1,
    CMD_QUERY   = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [NUM_W-1:0]   ticket_number;
    logic [AHEAD_W-1:0] alias_head;
    logic [ATAIL_W-1:0] alias_tail;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    found_number;
    logic [AHEAD_W-1:0]  found_alias_head;
    logic [ATAIL_W-1:0]  found_alias_tail;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    occupancy;
  } out_t;

  typedef struct packed {
    logic [NUM_W-1:0]   number;
    logic [AHEAD_W-1:0] alias_head;
    logic [ATAIL_W-1:0] alias_tail;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } stat_t;

endpackage

FILE: design/ufq_ram.sv
module ufq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/ufq_ctrl.sv
module ufq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ufq_pkg::stat_t  stat,
  output ufq_pkg::ctrl_t  ctrl
);

  ufq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    ctrl        = '0;
    case (state)
      ufq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load  = 1'b1;
          state_next = ufq_pkg::S_SCAN;
        end
      end
      ufq_pkg::S_SCAN: begin
        if (stat.finish) begin
          if (stat.out_free) begin
            ctrl.commit = 1'b1;
            state_next  = ufq_pkg::S_IDLE;
          end
        end else begin
          ctrl.step = 1'b1;
        end
      end
      default: begin
        state_next = ufq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/ufq_datapath.sv
module ufq_datapath #(
  parameter int QUEUE_DEPTH = ufq_pkg::DEFAULT_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  ufq_pkg::in_t    req,
  input  ufq_pkg::ctrl_t  ctrl,
  output ufq_pkg::stat_t  stat,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ufq_pkg::out_t   rsp
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ufq_pkg::in_t    cur;
  ufq_pkg::out_t   res;
  ufq_pkg::entry_t rd_entry;
  ufq_pkg::entry_t wr_entry;

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_off;
  logic [CW-1:0] rd_off;
  logic          rd_valid;

  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] rd_off_inc;
  logic          issue;
  logic          hit;
  logic          done;
  logic          full;
  logic          is_enq;
  logic          is_serve;
  logic          is_query;
  logic          wr_en;
  logic          pop;
  logic [$bits(ufq_pkg::entry_t)-1:0] rd_data;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [IW:0] sum;
    sum = (IW+1)'(base) + (IW+1)'(off);
    if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign rd_entry   = ufq_pkg::entry_t'(rd_data);
  assign wr_entry   = '{number: cur.ticket_number, alias_head: cur.alias_head,
                        alias_tail: cur.alias_tail};
  assign count_inc  = count + 1'b1;
  assign count_dec  = count - 1'b1;
  assign rd_off_inc = rd_off + 1'b1;
  assign full       = (count == CW'(QUEUE_DEPTH));
  assign is_enq     = (cur.command == ufq_pkg::CMD_ENQUEUE);
  assign is_serve   = (cur.command == ufq_pkg::CMD_SERVE);
  assign is_query   = (cur.command == ufq_pkg::CMD_QUERY);
  assign issue      = ctrl.step && (scan_off < count);
  assign hit        = rd_valid && (is_serve || (rd_entry.number == cur.ticket_number));
  assign done       = !rd_valid && (scan_off == count);

  assign stat.finish   = hit || done || !(is_enq || is_serve || is_query);
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_comb begin
    res           = '0;
    res.occupancy = ufq_pkg::POS_W'(count);
    wr_en         = 1'b0;
    pop           = 1'b0;
    case (cur.command)
      ufq_pkg::CMD_ENQUEUE: begin
        if (hit) begin
          res.status           = ufq_pkg::STAT_DUP;
          res.found_number     = rd_entry.number;
          res.found_alias_head = rd_entry.alias_head;
          res.found_alias_tail = rd_entry.alias_tail;
        end else if (full) begin
          res.status = ufq_pkg::STAT_FULL;
        end else begin
          wr_en         = ctrl.commit;
          res.occupancy = ufq_pkg::POS_W'(count_inc);
        end
      end
      ufq_pkg::CMD_SERVE: begin
        if (hit) begin
          res.found_number     = rd_entry.number;
          res.found_alias_head = rd_entry.alias_head;
          res.found_alias_tail = rd_entry.alias_tail;
          res.occupancy        = ufq_pkg::POS_W'(count_dec);
          pop                  = ctrl.commit;
        end else begin
          res.status = ufq_pkg::STAT_EMPTY;
        end
      end
      ufq_pkg::CMD_QUERY: begin
        if (hit) begin
          res.position = ufq_pkg::POS_W'(rd_off_inc);
        end else if (count == '0) begin
          res.status = ufq_pkg::STAT_EMPTY;
        end else begin
          res.status = ufq_pkg::STAT_NOTFOUND;
        end
      end
      default: begin
        res.status = ufq_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      scan_off  <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        scan_off <= '0;
        rd_valid <= 1'b0;
      end else if (ctrl.step) begin
        rd_valid <= issue;
        if (issue) begin
          scan_off <= scan_off + 1'b1;
        end
      end
      if (wr_en) begin
        count <= count_inc;
      end else if (pop) begin
        count <= count_dec;
        head  <= slot_of(head, CW'(1));
      end
      if (ctrl.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur <= req;
    end
    if (issue) begin
      rd_off <= scan_off;
    end
    if (ctrl.commit) begin
      rsp <= res;
    end
  end

  ufq_ram #(
    .WIDTH ($bits(ufq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_of(head, count)),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (slot_of(head, scan_off)),
    .rd_data (rd_data)
  );

endmodule

FILE: design/unique_ticket_fifo_with_position.sv
// Channel | Signals                      | Item
// --------+------------------------------+-------------------------------------------
// request | req_valid, req_ready, req    | command, ticket_number, alias_head/tail
// result  | rsp_valid, rsp_ready, rsp    | status, found fields, position, occupancy
//
// An item is taken while the block is idle; then the entry RAM's single read port
// compares one held entry per cycle from the head until a match or past the end of
// the queue, and a scan that finds nothing closes after its last compare (serve
// reads the head alone; a spare command code reads no entry).
// Reset clears head, count and handshake state; the entry RAM is not cleared.
// A finished result waits in the output register while the next item is taken;
// that item's scan holds at its end until the register is free.
module unique_ticket_fifo_with_position #(
  parameter int QUEUE_DEPTH = ufq_pkg::DEFAULT_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ufq_pkg::in_t   req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ufq_pkg::out_t  rsp
);

  ufq_pkg::ctrl_t ctrl;
  ufq_pkg::stat_t stat;

  ufq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ufq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: test/unique_ticket_fifo_with_position_tb.sv
`timescale 1ns / 100ps

module unique_ticket_fifo_with_position_tb;

  localparam int QUEUE_DEPTH = ufq_pkg::DEFAULT_DEPTH;
  localparam int FW = ufq_pkg::AHEAD_W;
  localparam logic [ufq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    ufq_pkg::in_t payload;
    int unsigned  gap;
    bit           drain;
  } request_slot_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  ufq_pkg::in_t  req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  ufq_pkg::out_t rsp;

  request_slot_t ticket_requests[$];
  ufq_pkg::out_t awaited_results[$];

  ufq_pkg::entry_t ticket_ring [QUEUE_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_held = 0;

  int unsigned req_issued = 0;
  int unsigned req_count = 0;
  int unsigned rsp_count = 0;
  int unsigned rsp_seen = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned status_tally [0:4] = '{default: 0};

  unique_ticket_fifo_with_position #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned ticket_offset(logic [ufq_pkg::NUM_W-1:0] number);
    for (int unsigned i = 0; i < ring_held; i++) begin
      if (ticket_ring[(ring_head + i) % QUEUE_DEPTH].number == number) begin
        return i;
      end
    end
    return ring_held;
  endfunction

  function automatic ufq_pkg::out_t ticket_outcome(ufq_pkg::in_t item);
    ufq_pkg::out_t r;
    int unsigned   hit;
    int unsigned   slot;
    r = '0;
    case (item.command)
      ufq_pkg::CMD_ENQUEUE: begin
        hit = ticket_offset(item.ticket_number);
        if (hit < ring_held) begin
          slot = (ring_head + hit) % QUEUE_DEPTH;
          r.status = ufq_pkg::STAT_DUP;
          r.found_number = ticket_ring[slot].number;
          r.found_alias_head = ticket_ring[slot].alias_head;
          r.found_alias_tail = ticket_ring[slot].alias_tail;
        end else if (ring_held >= QUEUE_DEPTH) begin
          r.status = ufq_pkg::STAT_FULL;
        end else begin
          slot = (ring_head + ring_held) % QUEUE_DEPTH;
          ticket_ring[slot].number = item.ticket_number;
          ticket_ring[slot].alias_head = item.alias_head;
          ticket_ring[slot].alias_tail = item.alias_tail;
          ring_held++;
        end
      end
      ufq_pkg::CMD_SERVE: begin
        if (ring_held == 0) begin
          r.status = ufq_pkg::STAT_EMPTY;
        end else begin
          r.found_number = ticket_ring[ring_head].number;
          r.found_alias_head = ticket_ring[ring_head].alias_head;
          r.found_alias_tail = ticket_ring[ring_head].alias_tail;
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_held--;
        end
      end
      ufq_pkg::CMD_QUERY: begin
        if (ring_held == 0) begin
          r.status = ufq_pkg::STAT_EMPTY;
        end else begin
          hit = ticket_offset(item.ticket_number);
          if (hit < ring_held) begin
            r.position = ufq_pkg::POS_W'(hit + 1);
          end else begin
            r.status = ufq_pkg::STAT_NOTFOUND;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = ufq_pkg::POS_W'(ring_held);
    return r;
  endfunction

  function automatic void check_field(string name, logic [FW-1:0] want,
                                      logic [FW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_request(logic [ufq_pkg::CMD_W-1:0] cmd,
                                       logic [ufq_pkg::NUM_W-1:0] number,
                                       logic [ufq_pkg::AHEAD_W-1:0] ahead,
                                       logic [ufq_pkg::ATAIL_W-1:0] atail,
                                       int unsigned gap, bit drain);
    request_slot_t s;
    s.payload.command = cmd;
    s.payload.ticket_number = number;
    s.payload.alias_head = ahead;
    s.payload.alias_tail = atail;
    s.gap = gap;
    s.drain = drain;
    ticket_requests.push_back(s);
  endfunction

  always @(negedge clk) begin : request_driver
    logic offer;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_count != req_issued)) begin
      offer = 1'b0;
      if (ticket_requests.size() != 0) begin
        if (ticket_requests[0].gap != 0) begin
          ticket_requests[0].gap = ticket_requests[0].gap - 1;
        end else if (!ticket_requests[0].drain || awaited_results.size() == 0) begin
          offer = 1'b1;
          req <= ticket_requests[0].payload;
          void'(ticket_requests.pop_front());
          req_issued++;
        end
      end
      req_valid <= offer;
    end
  end

  always @(negedge clk) begin : result_receiver
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_count != rsp_seen) begin
        rsp_seen = rsp_count;
        if (rsp_seen == 300 || rsp_seen == 700) begin
          stall_left = LONG_HOLD;
        end else if ((rsp_seen / 50) % 4 == 1) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 17);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    ufq_pkg::out_t want;
    bit            moved;
    if (!rst) begin
      moved = 1'b0;
      if (req_valid && req_ready) begin
        awaited_results.push_back(ticket_outcome(req));
        req_count++;
        moved = 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, rsp);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", FW'(want.status), FW'(rsp.status));
          check_field("found_number", FW'(want.found_number), FW'(rsp.found_number));
          check_field("found_alias_head", want.found_alias_head, rsp.found_alias_head);
          check_field("found_alias_tail", FW'(want.found_alias_tail),
                      FW'(rsp.found_alias_tail));
          check_field("position", FW'(want.position), FW'(rsp.position));
          check_field("occupancy", FW'(want.occupancy), FW'(rsp.occupancy));
        end
        if (rsp.status <= ufq_pkg::STAT_NOTFOUND) begin
          status_tally[rsp.status]++;
        end
        rsp_count++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, awaited_results.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned phase;
    int unsigned pick;
    int unsigned window_base;
    int unsigned gap;
    logic [ufq_pkg::CMD_W-1:0] cmd;
    logic [ufq_pkg::NUM_W-1:0] number;

    push_request(ufq_pkg::CMD_SERVE, 10'd0, '0, '0, 0, 1'b0);
    push_request(ufq_pkg::CMD_QUERY, 10'd5, '0, '0, 0, 1'b0);
    push_request(CMD_SPARE, 10'd1023, '1, '1, 0, 1'b0);
    push_request(ufq_pkg::CMD_ENQUEUE, 10'd0, '0, '0, 0, 1'b0);
    push_request(ufq_pkg::CMD_ENQUEUE, 10'd1023, '1, 8'hff, 0, 1'b0);
    push_request(ufq_pkg::CMD_ENQUEUE, 10'd0, {$urandom, $urandom}, 8'h41, 3, 1'b0);
    push_request(ufq_pkg::CMD_QUERY, 10'd1023, '0, '0, 0, 1'b0);
    push_request(ufq_pkg::CMD_QUERY, 10'd512, '0, '0, 0, 1'b0);
    for (int k = 1; k <= QUEUE_DEPTH - 2; k++) begin
      push_request(ufq_pkg::CMD_ENQUEUE, ufq_pkg::NUM_W'(k), {$urandom, $urandom},
                   ufq_pkg::ATAIL_W'($urandom_range(0, 255)), 0, 1'b0);
    end
    push_request(ufq_pkg::CMD_ENQUEUE, 10'd600, {$urandom, $urandom}, 8'h5a, 0, 1'b0);
    push_request(ufq_pkg::CMD_ENQUEUE, 10'd1023, {$urandom, $urandom}, 8'h00, 0, 1'b0);
    push_request(ufq_pkg::CMD_QUERY, ufq_pkg::NUM_W'(QUEUE_DEPTH - 2), '0, '0, 0, 1'b0);
    push_request(ufq_pkg::CMD_SERVE, 10'd0, '0, '0, 0, 1'b0);
    push_request(CMD_SPARE, 10'd0, '0, '0, 0, 1'b0);

    window_base = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 0) begin
        window_base = $urandom_range(0, 1000);
      end
      phase = (n / 80) % 3;
      pick = $urandom_range(0, 99);
      if (pick >= 97) begin
        cmd = CMD_SPARE;
      end else if (phase == 0) begin
        cmd = pick < 60 ? ufq_pkg::CMD_ENQUEUE :
              pick < 85 ? ufq_pkg::CMD_QUERY : ufq_pkg::CMD_SERVE;
      end else if (phase == 1) begin
        cmd = pick < 60 ? ufq_pkg::CMD_SERVE :
              pick < 80 ? ufq_pkg::CMD_QUERY : ufq_pkg::CMD_ENQUEUE;
      end else begin
        cmd = pick < 40 ? ufq_pkg::CMD_ENQUEUE :
              pick < 70 ? ufq_pkg::CMD_QUERY : ufq_pkg::CMD_SERVE;
      end
      if ($urandom_range(0, 9) < 7) begin
        number = ufq_pkg::NUM_W'(window_base + $urandom_range(0, 23));
      end else begin
        number = ufq_pkg::NUM_W'($urandom_range(0, 1023));
      end
      gap = ((n / 40) % 4 == 3) ? 0 : $urandom_range(0, 17);
      push_request(cmd, number, {$urandom, $urandom},
                   ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                   gap, n % 200 == 0);
    end
    total = ticket_requests.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_count < total || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests including empty, full, duplicate and spare-code cases.",
             req_count);
    $display("Results: %0d ok, %0d duplicate, %0d empty, %0d full, %0d not found.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
